// File: sv/sws_pkg.sv
`default_nettype none

package sws_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_LIST   = 2'd2,
        KIND_SEARCH = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_PUSHED    = 3'd0,
        ST_POPPED    = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_LISTED    = 3'd4,
        ST_FOUND     = 3'd5,
        ST_NOTFOUND  = 3'd6,
        ST_EMPTY     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WALK,
        S_FLUSH
    } state_t;

endpackage

`default_nettype wire

// File: sv/stack_with_search_top.sv
`default_nettype none

// channel   handshake        fields
// command   start / busy     kind[1:0], value[31:0]
// result    valid (1 cycle)  status[2:0], data[31:0], position[4:0], last
//
// push: result in the cycle after start, busy stays low, next word taken at once
// pop: one stack read through the registered memory port, answered from the S_POP state
// list and search walk the stored words top to bottom, one memory read and one
// compare per cycle; a search ends in the S_FLUSH state with its final word
// reset clears the word count and the sequencer; stored words are not cleared
// the receiver cannot stall; each result word is shown for one cycle only

module stack_with_search_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          kind,
    input  wire logic signed [sws_pkg::DATA_W-1:0]   value,
    output logic                                     valid,
    output logic [2:0]                               status,
    output logic signed [sws_pkg::DATA_W-1:0]        data,
    output logic [sws_pkg::POS_W-1:0]                position,
    output logic                                     last
);

    logic [sws_pkg::DATA_W-1:0] mem [sws_pkg::DEPTH];

    sws_pkg::state_t             state_reg, state_next;
    logic [sws_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [sws_pkg::ADDR_W-1:0]  idx_reg, idx_next;
    sws_pkg::kind_t              kind_reg, kind_next;
    logic [sws_pkg::DATA_W-1:0]  value_reg, value_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [sws_pkg::DATA_W-1:0]  pend_data_reg, pend_data_next;
    logic [sws_pkg::POS_W-1:0]   pend_pos_reg, pend_pos_next;

    logic                        valid_reg, valid_next;
    sws_pkg::status_t            status_reg, status_next;
    logic [sws_pkg::DATA_W-1:0]  data_reg, data_next;
    logic [sws_pkg::POS_W-1:0]   position_reg, position_next;
    logic                        last_reg, last_next;

    logic [sws_pkg::ADDR_W-1:0]  rd_addr;
    logic [sws_pkg::DATA_W-1:0]  rd_data_reg;
    logic                        wr_en;
    logic [sws_pkg::ADDR_W-1:0]  wr_addr;

    logic                        accept;
    logic [sws_pkg::CNT_W-1:0]   idx_ext;
    logic                        walk_end;
    logic [sws_pkg::POS_W-1:0]   walk_pos;
    logic                        match;

    assign accept   = start && !busy;
    assign busy     = (state_reg != sws_pkg::S_IDLE);
    assign idx_ext  = sws_pkg::CNT_W'(idx_reg);
    assign walk_end = ((idx_ext + 1'b1) == count_reg);
    assign walk_pos = sws_pkg::POS_W'(idx_ext + 1'b1);
    assign match    = (rd_data_reg == value_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        pend_pos_next   = pend_pos_reg;
        valid_next      = 1'b0;
        status_next     = status_reg;
        data_next       = '0;
        position_next   = '0;
        last_next       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = sws_pkg::ADDR_W'(count_reg);
        rd_addr         = sws_pkg::ADDR_W'(count_reg - 1'b1);

        case (state_reg)
            sws_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = sws_pkg::kind_t'(kind);
                    value_next      = value;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    case (sws_pkg::kind_t'(kind))
                        sws_pkg::KIND_PUSH:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            if (count_reg >= sws_pkg::CNT_W'(sws_pkg::DEPTH))
                            begin
                                status_next = sws_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                count_next  = count_reg + 1'b1;
                                status_next = sws_pkg::ST_PUSHED;
                            end
                        end
                        sws_pkg::KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                valid_next  = 1'b1;
                                last_next   = 1'b1;
                                status_next = sws_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                state_next = sws_pkg::S_POP;
                            end
                        end
                        sws_pkg::KIND_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                valid_next  = 1'b1;
                                last_next   = 1'b1;
                                status_next = sws_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                state_next = sws_pkg::S_WALK;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                valid_next  = 1'b1;
                                last_next   = 1'b1;
                                status_next = sws_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = sws_pkg::S_WALK;
                            end
                        end
                    endcase
                end
            end

            sws_pkg::S_POP:
            begin
                valid_next  = 1'b1;
                last_next   = 1'b1;
                status_next = sws_pkg::ST_POPPED;
                data_next   = rd_data_reg;
                state_next  = sws_pkg::S_IDLE;
            end

            sws_pkg::S_WALK:
            begin
                // rd_data_reg holds the word at position idx+1 from the top
                rd_addr  = sws_pkg::ADDR_W'(count_reg - idx_ext - 2'd2);
                idx_next = idx_reg + 1'b1;
                if (kind_reg == sws_pkg::KIND_LIST)
                begin
                    valid_next    = 1'b1;
                    status_next   = sws_pkg::ST_LISTED;
                    data_next     = rd_data_reg;
                    position_next = walk_pos;
                    last_next     = walk_end;
                    if (walk_end)
                    begin
                        state_next = sws_pkg::S_IDLE;
                    end
                end
                else
                begin
                    // a match is held back until we know whether another follows
                    if (match)
                    begin
                        if (pend_valid_reg)
                        begin
                            valid_next    = 1'b1;
                            status_next   = sws_pkg::ST_FOUND;
                            data_next     = pend_data_reg;
                            position_next = pend_pos_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_data_next  = rd_data_reg;
                        pend_pos_next   = walk_pos;
                    end
                    if (walk_end)
                    begin
                        state_next = sws_pkg::S_FLUSH;
                    end
                end
            end

            sws_pkg::S_FLUSH:
            begin
                valid_next = 1'b1;
                last_next  = 1'b1;
                state_next = sws_pkg::S_IDLE;
                if (pend_valid_reg)
                begin
                    status_next   = sws_pkg::ST_FOUND;
                    data_next     = pend_data_reg;
                    position_next = pend_pos_reg;
                end
                else
                begin
                    status_next = sws_pkg::ST_NOTFOUND;
                end
            end

            default:
            begin
                state_next = sws_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sws_pkg::S_IDLE;
            count_reg      <= '0;
            valid_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        kind_reg      <= kind_next;
        value_reg     <= value_next;
        pend_data_reg <= pend_data_next;
        pend_pos_reg  <= pend_pos_next;
        status_reg    <= status_next;
        data_reg      <= data_next;
        position_reg  <= position_next;
        last_reg      <= last_next;
    end

    assign valid    = valid_reg;
    assign status   = status_reg;
    assign data     = data_reg;
    assign position = position_reg;
    assign last     = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sws_pkg::CNT_W'(sws_pkg::DEPTH))
        else $error("word count beyond depth");

    a_push_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind == sws_pkg::KIND_PUSH |=> valid && last && !busy)
        else $error("push did not answer with a single final word");

    a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sws_pkg::S_POP |=> valid && last
            && status_reg == sws_pkg::ST_POPPED && state_reg == sws_pkg::S_IDLE)
        else $error("pop result missing");

    a_walk_position: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status_reg == sws_pkg::ST_LISTED || status_reg == sws_pkg::ST_FOUND)
            |-> position != '0)
        else $error("listed or found word without position");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sws_pkg::S_FLUSH |=> valid && last)
        else $error("search ended without final word");

endmodule

`default_nettype wire
